### src/ascii_decimal_to_fixed_parser_top_assert.svh
// Assertion macros for the ASCII decimal parser.
`ifndef ASCII_DECIMAL_TO_FIXED_PARSER_TOP_ASSERT_SVH
`define ASCII_DECIMAL_TO_FIXED_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ADFP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cond must never be true outside reset
`define ADFP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ADFP_ASSERT(lbl, clk, rst_n, prop, msg)
`define ADFP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### src/adfp_pkg.sv
// Package for the ASCII decimal parser: widths, constants, types.
`default_nettype none

package adfp_pkg;

	localparam int INT_BITS   = 40;
	localparam int FRAC_BITS  = 24;
	localparam int COUNT_BITS = 16;

	localparam int VALUE_W = 64;
	localparam int CONS_W  = 16;

	localparam logic [31:0] TENTH_Q32 = 32'h1999_9999;

	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_HT    = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	// integer range limits split as limit = 10*q + r
	localparam logic [63:0] LIM_NEG64 = 64'd1 << (INT_BITS - 1);
	localparam logic [63:0] LIM_POS64 = LIM_NEG64 - 64'd1;
	localparam logic [INT_BITS-1:0] LIM_NEG_Q = INT_BITS'(LIM_NEG64 / 64'd10);
	localparam logic [3:0]          LIM_NEG_R = 4'(LIM_NEG64 % 64'd10);
	localparam logic [INT_BITS-1:0] LIM_POS_Q = INT_BITS'(LIM_POS64 / 64'd10);
	localparam logic [3:0]          LIM_POS_R = 4'(LIM_POS64 % 64'd10);

	localparam bit          CAP_EN = (INT_BITS + FRAC_BITS <= VALUE_W);
	localparam logic [63:0] CAP64  = 64'd1 << (INT_BITS - 1 + FRAC_BITS);

	localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
	localparam logic [CONS_W-1:0]     CONS_MAX = {CONS_W{1'b1}};

	typedef enum logic [2:0] {
		PH_DONE = 3'd0,
		PH_WS   = 3'd1,
		PH_INT  = 3'd2,
		PH_DOT  = 3'd3,
		PH_FRAC = 3'd4
	} phase_t;

	typedef struct packed {
		phase_t                  phase;
		logic                    negative;
		logic [INT_BITS-1:0]     int_acc;
		logic [31:0]             frac_acc;
		logic [31:0]             frac_scale;
		logic [COUNT_BITS-1:0]   char_count;
		logic                    err_flag;
	} state_t;

	typedef struct packed {
		logic       start_req;
		logic [7:0] ch;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      overflow;
		logic [CONS_W-1:0]         consumed;
	} result_t;

endpackage

`default_nettype wire

### src/ascii_decimal_to_fixed_parser_top.sv
// ASCII decimal string parser producing signed Q40.24 fixed point.
//
// item channel: one ASCII character per transaction; start_req marks the first
// character of a new number. Leading whitespace, an optional sign, integer
// digits, an optional dot and fraction digits are taken; the first character
// that cannot continue the number ends it and yields one result transaction.
// A dot with no digit after it ends the number and is not counted.
// result channel: value (Q40.24), overflow (value then zero) and consumed.
// Throughput: one character per cycle unless a pending result is stalled. A character
// is registered at acceptance; a combinational step (one 32x32 multiply for the fraction
// weight, a shift-add for the integer) then updates the parser state and loads the
// result register when the registered character fires. Result valid rises when the
// step for the character that ends the number loads the result register.
// When the receiver stalls with a result pending, the input register holds
// its character and item_ready drops until the result is taken.
// Reset clears both registers' valid bits and returns the parser to idle;
// characters arriving without start_req while idle are dropped silently.
`default_nettype none

`include "ascii_decimal_to_fixed_parser_top_assert.svh"

module ascii_decimal_to_fixed_parser_top import adfp_pkg::*; (
	input  wire     clk,
	input  wire     arst_n,
	input  wire     item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  wire     result_ready,
	output result_t result
);

	item_t   item_s1;
	logic    valid_s1;
	state_t  state_q;
	state_t  state_nxt;
	logic    emit;
	result_t res_nxt;
	result_t result_q;
	logic    result_valid_q;
	logic    fire;

	assign fire       = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid)
			item_s1 <= item;
	end

	adfp_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.emit (emit),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (fire)
				state_q <= state_nxt;
			if (fire && emit)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit)
			result_q <= res_nxt;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`ADFP_ASSERT(a_rise_needs_fire, clk, arst_n, $rose(result_valid_q) |-> $past(fire && emit), "result valid rose without a step")
	`ADFP_ASSERT(a_stall_cause, clk, arst_n, !item_ready |-> (valid_s1 && result_valid_q && !result_ready), "input stalled without output stall")
	`ADFP_ASSERT(a_ovf_zero, clk, arst_n, (result_valid_q && result_q.overflow) |-> (result_q.value == 64'sd0), "overflow result with nonzero value")
	`ADFP_ASSERT(a_done_after_emit, clk, arst_n, (fire && emit) |=> (state_q.phase == PH_DONE), "parser not idle after result")
	`ADFP_ASSERT_NEVER(a_no_lost_result, clk, arst_n, fire && emit && result_valid_q && !result_ready, "result overwritten while pending")

endmodule

`default_nettype wire

### src/adfp_step.sv
// One-character parse step: next parser state and the finished result.
`default_nettype none

module adfp_step import adfp_pkg::*; (
	input  state_t  cur,
	input  item_t   item,
	output state_t  nxt,
	output logic    emit,
	output result_t res
);

	state_t                  e;
	phase_t                  nph;
	logic                    is_digit;
	logic                    is_space;
	logic                    is_sign;
	logic                    is_dot;
	logic [3:0]              d;
	logic [INT_BITS-1:0]     lim_q;
	logic [3:0]              lim_r;
	logic                    int_ovf;
	logic [INT_BITS-1:0]     int_mac;
	logic [31:0]             scale_use;
	logic [35:0]             frac_sum;
	logic [31:0]             frac_sat;
	logic [63:0]             scale_prod;
	logic [1:0]              inc;
	logic [COUNT_BITS:0]     cnt_sum;
	logic [COUNT_BITS-1:0]   cnt_sat;
	logic [63:0]             mag;

	always_comb begin
		e = cur;
		if (item.start_req) begin
			e = '0;
			e.phase = PH_WS;
		end
	end

	assign is_digit = (item.ch >= CH_0) && (item.ch <= CH_9);
	assign is_space = (item.ch == CH_SP) || ((item.ch >= CH_HT) && (item.ch <= CH_CR));
	assign is_sign  = (item.ch == CH_PLUS) || (item.ch == CH_MINUS);
	assign is_dot   = (item.ch == CH_DOT);
	assign d        = 4'(item.ch - CH_0);

	// next phase
	always_comb begin
		case (e.phase)
			PH_WS: begin
				if (is_space)
					nph = PH_WS;
				else if (is_sign || is_digit)
					nph = PH_INT;
				else
					nph = PH_DONE;
			end
			PH_INT: begin
				if (is_digit)
					nph = PH_INT;
				else if (is_dot)
					nph = PH_DOT;
				else
					nph = PH_DONE;
			end
			PH_DOT:  nph = is_digit ? PH_FRAC : PH_DONE;
			PH_FRAC: nph = is_digit ? PH_FRAC : PH_DONE;
			default: nph = PH_DONE;
		endcase
	end

	always_comb begin
		case (e.phase)
			PH_WS:   emit = !(is_space || is_sign || is_digit);
			PH_INT:  emit = !(is_digit || is_dot);
			PH_DOT:  emit = !is_digit;
			PH_FRAC: emit = !is_digit;
			default: emit = 1'b0;
		endcase
	end

	// integer digit
	assign lim_q   = e.negative ? LIM_NEG_Q : LIM_POS_Q;
	assign lim_r   = e.negative ? LIM_NEG_R : LIM_POS_R;
	assign int_ovf = (e.int_acc > lim_q) || ((e.int_acc == lim_q) && (d > lim_r));
	assign int_mac = (e.int_acc << 3) + (e.int_acc << 1) + INT_BITS'(d);

	// fraction digit, weight restarts at 0.1 after the dot
	assign scale_use  = (e.phase == PH_DOT) ? TENTH_Q32 : e.frac_scale;
	assign frac_sum   = 36'(e.frac_acc) + 36'(d) * 36'(scale_use);
	assign frac_sat   = (frac_sum[35:32] != 4'd0) ? 32'hFFFF_FFFF : frac_sum[31:0];
	assign scale_prod = 64'(scale_use) * 64'(TENTH_Q32);

	// the dot is counted together with the first fraction digit
	assign inc     = (e.phase == PH_DOT) ? 2'd2 : 2'd1;
	assign cnt_sum = (COUNT_BITS + 1)'(e.char_count) + (COUNT_BITS + 1)'(inc);
	assign cnt_sat = cnt_sum[COUNT_BITS] ? CNT_MAX : cnt_sum[COUNT_BITS-1:0];

	always_comb begin
		nxt = e;
		nxt.phase = nph;
		case (e.phase)
			PH_WS: begin
				if (is_space) begin
					nxt.char_count = cnt_sat;
				end else if (is_sign) begin
					nxt.negative   = (item.ch == CH_MINUS);
					nxt.char_count = cnt_sat;
				end else if (is_digit) begin
					nxt.char_count = cnt_sat;
					if (!e.err_flag) begin
						if (int_ovf) begin
							nxt.err_flag = 1'b1;
							nxt.int_acc  = '0;
						end else begin
							nxt.int_acc = int_mac;
						end
					end
				end
			end
			PH_INT: begin
				if (is_digit) begin
					nxt.char_count = cnt_sat;
					if (!e.err_flag) begin
						if (int_ovf) begin
							nxt.err_flag = 1'b1;
							nxt.int_acc  = '0;
						end else begin
							nxt.int_acc = int_mac;
						end
					end
				end
			end
			PH_DOT, PH_FRAC: begin
				if (is_digit) begin
					nxt.char_count = cnt_sat;
					nxt.frac_scale = scale_use;
					if (!e.err_flag) begin
						nxt.frac_acc   = frac_sat;
						nxt.frac_scale = scale_prod[63:32];
					end
				end
			end
			default: begin
				nxt = e;
			end
		endcase
	end

	// result of the number held before this character
	always_comb begin
		mag = (64'(e.int_acc) << FRAC_BITS) + 64'(e.frac_acc >> (32 - FRAC_BITS));
		if (CAP_EN && e.negative && (mag > CAP64))
			mag = CAP64;
		if (e.err_flag)
			mag = '0;
		res.value    = e.negative ? signed'(64'd0 - mag) : signed'(mag);
		res.overflow = e.err_flag;
		if ((COUNT_BITS > CONS_W) && (32'(e.char_count) > 32'(CONS_MAX)))
			res.consumed = CONS_MAX;
		else
			res.consumed = CONS_W'(e.char_count);
	end

endmodule

`default_nettype wire

### test/adfp_parse_checker.sv
// Scoreboard for the ASCII decimal parser: predicts each parsed number and compares results.
`default_nettype none

module adfp_parse_checker import adfp_pkg::*; (
	input  wire     clk,
	input  wire     arst_n,
	input  wire     item_valid,
	input  wire     item_ready,
	input  item_t   item,
	input  wire     result_valid,
	input  wire     result_ready,
	input  result_t result,
	output int      errors,
	output int      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] TENTH      = 32'h1999_9999;
	localparam logic [63:0] NEG_LIMIT  = 64'd1 << (INT_BITS - 1);
	localparam logic [63:0] POS_LIMIT  = NEG_LIMIT - 64'd1;
	localparam logic [63:0] NEG_CAP    = 64'd1 << (INT_BITS - 1 + FRAC_BITS);
	localparam logic [15:0] COUNT_TOP  = 16'hFFFF;

	phase_t      ph;
	bit          neg;
	logic [63:0] int_part;
	logic [31:0] frac_part;
	logic [31:0] weight;
	logic [15:0] nchars;
	bit          too_big;

	result_t expected_numbers[$];

	function void clear_parse();
		ph = PH_DONE;
		neg = 0;
		int_part = '0;
		frac_part = '0;
		weight = '0;
		nchars = '0;
		too_big = 0;
	endfunction

	function void bump_count();
		if (nchars != COUNT_TOP)
			nchars = nchars + 16'd1;
	endfunction

	function void add_int_digit(logic [3:0] d);
		logic [63:0] lim;
		lim = neg ? NEG_LIMIT : POS_LIMIT;
		bump_count();
		if (too_big)
			return;
		if (int_part > lim / 10 || (int_part == lim / 10 && 64'(d) > lim % 10)) begin
			too_big = 1;
			int_part = '0;
		end else begin
			int_part = int_part * 10 + 64'(d);
		end
	endfunction

	function void add_frac_digit(logic [3:0] d);
		logic [63:0] sum;
		logic [63:0] prod;
		bump_count();
		if (too_big)
			return;
		sum = {32'd0, frac_part} + 64'(d) * {32'd0, weight};
		frac_part = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
		prod = {32'd0, weight} * {32'd0, TENTH};
		weight = prod[63:32];
	endfunction

	function result_t close_number();
		result_t r;
		logic [63:0] mag;
		mag = '0;
		if (!too_big) begin
			mag = (int_part << FRAC_BITS) + ({32'd0, frac_part} >> (32 - FRAC_BITS));
			if (neg && mag > NEG_CAP)
				mag = NEG_CAP;
		end
		r.value = neg ? -mag : mag;
		r.overflow = too_big;
		r.consumed = nchars;
		ph = PH_DONE;
		return r;
	endfunction

	function automatic bit parse_char(input item_t it, output result_t r);
		logic [7:0] c;
		bit digit;
		c = it.ch;
		digit = (c >= CH_0 && c <= CH_9);
		r = '0;
		if (it.start_req) begin
			clear_parse();
			ph = PH_WS;
		end
		case (ph)
			PH_WS: begin
				if (c == CH_SP || (c >= CH_HT && c <= CH_CR)) begin
					bump_count();
					return 0;
				end
				if (c == CH_PLUS || c == CH_MINUS) begin
					neg = (c == CH_MINUS);
					bump_count();
					ph = PH_INT;
					return 0;
				end
				if (digit) begin
					ph = PH_INT;
					add_int_digit(4'(c - CH_0));
					return 0;
				end
				r = close_number();
				return 1;
			end
			PH_INT: begin
				if (digit) begin
					add_int_digit(4'(c - CH_0));
					return 0;
				end
				if (c == CH_DOT) begin
					ph = PH_DOT;
					return 0;
				end
				r = close_number();
				return 1;
			end
			PH_DOT: begin
				if (digit) begin
					bump_count();
					weight = TENTH;
					ph = PH_FRAC;
					add_frac_digit(4'(c - CH_0));
					return 0;
				end
				r = close_number();
				return 1;
			end
			PH_FRAC: begin
				if (digit) begin
					add_frac_digit(4'(c - CH_0));
					return 0;
				end
				r = close_number();
				return 1;
			end
			default: return 0;
		endcase
		return 0;
	endfunction

	function void flag_field(string what, logic [63:0] want, logic [63:0] got);
		if (errors < 10)
			$display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
		errors++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t fresh;
		if (!arst_n) begin
			clear_parse();
			expected_numbers.delete();
			pending = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_numbers.size() == 0) begin
					if (errors < 10)
						$display("%0t: unexpected result transaction: value %0h overflow %0b consumed %0d",
							$realtime, result.value, result.overflow, result.consumed);
					errors++;
				end else begin
					want = expected_numbers.pop_front();
					if (result.value !== want.value)
						flag_field("value", want.value, result.value);
					if (result.overflow !== want.overflow)
						flag_field("overflow", 64'(want.overflow), 64'(result.overflow));
					if (result.consumed !== want.consumed)
						flag_field("consumed", 64'(want.consumed), 64'(result.consumed));
				end
			end
			if (item_valid && item_ready) begin
				if (parse_char(item, fresh))
					expected_numbers.push_back(fresh);
			end
			pending = expected_numbers.size();
		end
	end

endmodule

`default_nettype wire

### test/ascii_decimal_to_fixed_parser_top_test.sv
// Testbench top for the ASCII decimal parser: character stimulus, result stalls and verdict.
`default_nettype none

module ascii_decimal_to_fixed_parser_top_test import adfp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	wire     item_ready;
	item_t   item;
	wire     result_valid;
	logic    result_ready;
	result_t result;
	int      errors;
	int      pending;

	int send_idle = 0;
	int recv_stall = 0;
	bit burst_req = 0;
	bit burst_done = 0;
	int burst_left = 0;
	int cycles = 0;

	ascii_decimal_to_fixed_parser_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	adfp_parse_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.errors       (errors),
		.pending      (pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("ascii_decimal_to_fixed_parser_top test failed");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		result_ready = 0;
		forever begin
			@(posedge clk);
			if (burst_req && !burst_done) begin
				burst_done = 1;
				burst_left = 300;
			end
			if (burst_left > 0) begin
				burst_left--;
				result_ready <= 0;
			end else begin
				result_ready <= ($urandom_range(99, 0) >= recv_stall);
			end
		end
	end

	task automatic send_char(input bit first, input logic [7:0] c);
		while ($urandom_range(99, 0) < send_idle) begin
			item_valid <= 0;
			@(posedge clk);
		end
		item_valid <= 1;
		item <= {first, c};
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
	endtask

	task automatic send_text(input bit first, input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(first && i == 0, s[i]);
	endtask

	function automatic logic [7:0] rand_digit();
		return CH_0 + 8'($urandom_range(9, 0));
	endfunction

	// one number with random shape; returns the characters sent
	task automatic send_number(output int sent);
		bit first;
		int n;
		int mode;
		logic [7:0] c;
		first = 1;
		sent = 0;
		n = $urandom_range(2, 0);
		repeat (n) begin
			c = ($urandom_range(5, 0) == 0) ? CH_SP : CH_HT + 8'($urandom_range(4, 0));
			send_char(first, c);
			first = 0;
			sent++;
		end
		case ($urandom_range(3, 0))
			0: begin send_char(first, CH_PLUS); first = 0; sent++; end
			1: begin send_char(first, CH_MINUS); first = 0; sent++; end
			default: ;
		endcase
		mode = $urandom_range(9, 0);
		if (mode == 0) begin
			send_text(first, "5497558138");
			send_char(0, CH_0 + 8'($urandom_range(9, 7)));
			send_char(0, rand_digit());
			first = 0;
			sent += 12;
		end else begin
			n = (mode == 1) ? $urandom_range(15, 11) : $urandom_range(7, 0);
			repeat (n) begin
				send_char(first, rand_digit());
				first = 0;
				sent++;
			end
		end
		if ($urandom_range(2, 0) != 0) begin
			send_char(first, CH_DOT);
			first = 0;
			sent++;
			n = $urandom_range(10, 0);
			repeat (n) begin
				send_char(0, rand_digit());
				sent++;
			end
		end
		if ($urandom_range(7, 0) != 0) begin
			c = 8'($urandom_range(255, 0));
			if ((c >= CH_0 && c <= CH_9) || c == CH_DOT)
				c = 8'h2C;
			send_char(first, c);
			sent++;
		end
	endtask

	task automatic random_phase(input int target);
		int done;
		int sent;
		int n;
		done = 0;
		while (done < target) begin
			if ($urandom_range(9, 0) == 0) begin
				n = $urandom_range(4, 1);
				repeat (n) begin
					send_char($urandom_range(3, 0) == 0, 8'($urandom_range(255, 0)));
					done++;
				end
			end else begin
				send_number(sent);
				done += sent;
			end
		end
	endtask

	initial begin
		arst_n = 0;
		item_valid = 0;
		item = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_text(1, "549755813887 ");
		send_text(1, "549755813888;");
		send_text(1, "-549755813888.5;");
		send_text(1, "-.5");
		send_text(1, "12.x");
		send_text(1, "-x");
		send_char(0, 8'h5A);
		send_text(1, "77");
		send_char(1, 8'h00);
		send_char(1, 8'd11);
		send_char(0, 8'd12);
		send_text(0, "+9.9");
		send_char(0, 8'hFF);

		burst_req = 1;
		random_phase(410);
		send_idle = 84;
		recv_stall = 0;
		random_phase(410);
		send_idle = 0;
		recv_stall = 84;
		random_phase(410);
		send_idle = 23;
		recv_stall = 23;
		random_phase(420);
		item_valid <= 0;

		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("ascii_decimal_to_fixed_parser_top test passed");
		else
			$display("ascii_decimal_to_fixed_parser_top test failed");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
+incdir+src
src/adfp_pkg.sv
src/adfp_step.sv
src/ascii_decimal_to_fixed_parser_top.sv
test/adfp_parse_checker.sv
test/ascii_decimal_to_fixed_parser_top_test.sv
